// ===== hdl/bscg_pkg.sv =====
// shared types and constants for the 3d box-sum coarse graining block
// used by bscg_rmw, bscg_outq and the top level; no dependencies
`default_nettype none

package bscg_pkg;

	localparam int SAMPLE_W = 32;
	localparam int POS_W    = 6;
	localparam int BOX_W    = 5;
	localparam int SUM_W    = 44;
	localparam int BSL_W    = 3;
	localparam int ADDR_W   = 3 * BOX_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	localparam logic FUNC_ACC  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [BSL_W-1:0] BSL_MIN   = 3'd1;
	localparam logic [BSL_W-1:0] BSL_MAX   = 3'd4;
	localparam logic [BSL_W-1:0] BSL_RESET = 3'd1;

	typedef struct packed {
		logic                func;
		logic [SAMPLE_W-1:0] sample_value;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [POS_W-1:0]    pos_z;
		logic [BOX_W-1:0]    box_x;
		logic [BOX_W-1:0]    box_y;
		logic [BOX_W-1:0]    box_z;
	} in_word_t;

	typedef struct packed {
		logic [SUM_W-1:0] box_sum;
		logic             box_nonzero;
	} out_word_t;

	// result handed from the update pipeline to the output queue
	typedef struct packed {
		logic      push;
		out_word_t word;
	} res_push_t;

endpackage

`default_nettype wire

// ===== hdl/bscg_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
`default_nettype none

module bscg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/bscg_rmw.sv =====
// box-sum store with read-modify-write pipeline, write forwarding and
// post-reset clearing sweep; depends on bscg_pkg and bscg_ram
`default_nettype none

module bscg_rmw #(
	parameter int GRID_LOG2 = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [bscg_pkg::BSL_W-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire bscg_pkg::in_word_t           in_data,
	input  wire logic [1:0]                   oq_used_next,
	output      bscg_pkg::res_push_t          res
);

	localparam int LIM_W = GRID_LOG2 + 1;
	localparam int CMP_W = (LIM_W > bscg_pkg::POS_W) ? LIM_W : bscg_pkg::POS_W;
	localparam int AW    = bscg_pkg::ADDR_W;
	localparam int SW    = bscg_pkg::SUM_W;

	logic [bscg_pkg::BSL_W-1:0] bsl_q;
	logic [bscg_pkg::BSL_W-1:0] b_eff;
	logic [LIM_W-1:0]           grid_c;
	logic [LIM_W-1:0]           limit;
	logic [bscg_pkg::POS_W-1:0] sx, sy, sz;
	logic                       drop;
	logic                       is_read;
	logic [AW-1:0]              rd_addr;
	logic                       accept;
	logic                       issue;

	logic                          clr_q;
	logic [AW-1:0]                 clr_addr_q;
	logic                          valid_s1;
	logic                          read_s1;
	logic [AW-1:0]                 addr_s1;
	logic [bscg_pkg::SAMPLE_W-1:0] sample_s1;
	logic                          fwd_hit_s1;
	logic [SW-1:0]                 fwd_data_s1;

	logic [SW-1:0] ram_rdata;
	logic [SW-1:0] base;
	logic [SW:0]   sum_w;
	logic [SW-1:0] wr_val;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [SW-1:0] ram_wdata;
	logic          pend_read;

	// box size clamped to the legal range
	always_comb begin
		priority if (bsl_q < bscg_pkg::BSL_MIN) begin
			b_eff = bscg_pkg::BSL_MIN;
		end else if (bsl_q > bscg_pkg::BSL_MAX) begin
			b_eff = bscg_pkg::BSL_MAX;
		end else begin
			b_eff = bsl_q;
		end
	end

	// positions at or past the last whole box are dropped
	assign grid_c = LIM_W'(1) << GRID_LOG2;
	assign limit  = (grid_c >> b_eff) << b_eff;
	assign drop   = (CMP_W'(in_data.pos_x) >= CMP_W'(limit)) ||
	                (CMP_W'(in_data.pos_y) >= CMP_W'(limit)) ||
	                (CMP_W'(in_data.pos_z) >= CMP_W'(limit));

	assign sx = in_data.pos_x >> b_eff;
	assign sy = in_data.pos_y >> b_eff;
	assign sz = in_data.pos_z >> b_eff;

	assign is_read = (in_data.func == bscg_pkg::FUNC_READ);
	assign rd_addr = is_read ? {in_data.box_x, in_data.box_y, in_data.box_z}
	                         : {sx[bscg_pkg::BOX_W-1:0], sy[bscg_pkg::BOX_W-1:0],
	                            sz[bscg_pkg::BOX_W-1:0]};

	// a read in flight plus what the queue still holds must leave a slot free
	assign pend_read = valid_s1 && read_s1;
	assign in_ready  = !clr_q && (({1'b0, oq_used_next} + {2'b00, pend_read}) <= 3'd1);
	assign accept    = in_valid && in_ready;
	assign issue     = accept && (is_read || !drop);

	// forward the word written last cycle, the ram read saw the old value
	assign base   = fwd_hit_s1 ? fwd_data_s1 : ram_rdata;
	assign sum_w  = {1'b0, base} + (SW + 1)'(sample_s1);
	assign wr_val = read_s1 ? '0 : (sum_w[SW] ? '1 : sum_w[SW-1:0]);

	assign ram_we    = clr_q || valid_s1;
	assign ram_waddr = clr_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clr_q ? '0 : wr_val;

	assign res.push             = pend_read;
	assign res.word.box_sum     = base;
	assign res.word.box_nonzero = (base != '0);

	bscg_ram #(
		.WIDTH(SW),
		.DEPTH(bscg_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsl_q      <= bscg_pkg::BSL_RESET;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				bsl_q <= cfg_wdata;
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			read_s1     <= is_read;
			addr_s1     <= rd_addr;
			sample_s1   <= in_data.sample_value;
			fwd_hit_s1  <= valid_s1 && (addr_s1 == rd_addr);
			fwd_data_s1 <= wr_val;
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !issue && !valid_s1)
		else $error("item taken while the store is being cleared");

	a_clear_covers_store: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_addr_q) == '1)
		else $error("clearing sweep ended before the last entry");

	a_fwd_only_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		issue && valid_s1 && (addr_s1 == rd_addr) |=> valid_s1 && fwd_hit_s1)
		else $error("back-to-back access to one entry not forwarded");

endmodule

`default_nettype wire

// ===== hdl/bscg_outq.sv =====
// two-word result queue between the update pipeline and the output channel
// depends on bscg_pkg
`default_nettype none

module bscg_outq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bscg_pkg::res_push_t res,
	output      logic [1:0]          used_next,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      bscg_pkg::out_word_t out_data
);

	logic [1:0]          count_q;
	bscg_pkg::out_word_t head_q;
	bscg_pkg::out_word_t tail_q;
	logic                pop;

	assign out_valid = (count_q != 2'd0);
	assign out_data  = head_q;
	assign pop       = out_valid && out_ready;
	assign used_next = count_q - {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q - {1'b0, pop} + {1'b0, res.push};
		end
	end

	always_ff @(posedge clk) begin
		// the pushed word lands in the first free slot after the pop
		if (res.push && (used_next == 2'd0)) begin
			head_q <= res.word;
		end else if (pop) begin
			head_q <= tail_q;
		end
		if (res.push && (used_next != 2'd0)) begin
			tail_q <= res.word;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res.push |-> used_next != 2'd2)
		else $error("result pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("waiting result word changed or dropped");

endmodule

`default_nettype wire

// ===== hdl/box_sum_coarse_graining_3d.sv =====
// top level of the 3d box-sum coarse graining block
// depends on bscg_pkg, bscg_rmw, bscg_outq
`default_nettype none

// Sums samples of a cubic grid (edge 2^GRID_LOG2) into cubic boxes of edge
// 2^box_size_log2 held in a 32768 x 44 bit single-port-write ram. After reset
// the store is swept to zero, one entry per cycle; in_ready stays low during
// the sweep while register writes are still taken. After that a word is taken
// every cycle while in_ready is high: the ram read is registered, the add and
// write back follow in the next cycle, and a write-to-read bypass covers a
// following word to the same box. A read word returns its sum through the
// registered ram read and a two-deep result queue. With out_ready held high
// reads and accumulates both go one per cycle; in_ready drops for every word
// while the queue is full, or holds one word with a read still in flight.
module box_sum_coarse_graining_3d #(
	parameter int GRID_LOG2 = 6
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [bscg_pkg::BSL_W-1:0] cfg_wdata,
	input  wire logic                       in_valid,
	output      logic                       in_ready,
	input  wire bscg_pkg::in_word_t         in_data,
	output      logic                       out_valid,
	input  wire logic                       out_ready,
	output      bscg_pkg::out_word_t        out_data
);

	bscg_pkg::res_push_t res;
	logic [1:0]          oq_used_next;

	bscg_rmw #(
		.GRID_LOG2(GRID_LOG2)
	) u_rmw (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.oq_used_next(oq_used_next),
		.res         (res)
	);

	bscg_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.used_next(oq_used_next),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
